// File: rtl/core/pst_pkg.sv
// shared types, codes and constants of the stream tokenizer
`timescale 1ns / 1ps
package pst_pkg;

	localparam int unsigned CfgAddrW = 1;

	// configuration register indexes
	localparam logic [CfgAddrW-1:0] CFG_CODES_LOW  = 1'b0;
	localparam logic [CfgAddrW-1:0] CFG_CODES_HIGH = 1'b1;

	// token kinds
	localparam logic [3:0] K_NULL   = 4'd0;
	localparam logic [3:0] K_BOOL   = 4'd1;
	localparam logic [3:0] K_INT    = 4'd2;
	localparam logic [3:0] K_FLOAT  = 4'd3;
	localparam logic [3:0] K_STR    = 4'd4;
	localparam logic [3:0] K_BYTES  = 4'd5;
	localparam logic [3:0] K_LIST   = 4'd6;
	localparam logic [3:0] K_MAP    = 4'd7;
	localparam logic [3:0] K_STRUCT = 4'd8;
	localparam logic [3:0] K_PAY    = 4'd9;
	localparam logic [3:0] K_ERR    = 4'd10;

	// error codes
	localparam logic [1:0] E_NONE     = 2'd0;
	localparam logic [1:0] E_MARKER   = 2'd1;
	localparam logic [1:0] E_NEG_SIZE = 2'd2;
	localparam logic [1:0] E_SIG      = 2'd3;

	// fixed markers
	localparam logic [7:0] M_NULL    = 8'hC0;
	localparam logic [7:0] M_FLOAT   = 8'hC1;
	localparam logic [7:0] M_FALSE   = 8'hC2;
	localparam logic [7:0] M_TRUE    = 8'hC3;
	localparam logic [7:0] M_INT8    = 8'hC8;
	localparam logic [7:0] M_INT16   = 8'hC9;
	localparam logic [7:0] M_INT32   = 8'hCA;
	localparam logic [7:0] M_INT64   = 8'hCB;
	localparam logic [7:0] M_BYTES8  = 8'hCC;
	localparam logic [7:0] M_BYTES16 = 8'hCD;
	localparam logic [7:0] M_BYTES32 = 8'hCE;
	localparam logic [7:0] M_STR8    = 8'hD0;
	localparam logic [7:0] M_STR16   = 8'hD1;
	localparam logic [7:0] M_STR32   = 8'hD2;
	localparam logic [7:0] M_LIST8   = 8'hD4;
	localparam logic [7:0] M_LIST16  = 8'hD5;
	localparam logic [7:0] M_LIST32  = 8'hD6;
	localparam logic [7:0] M_MAP8    = 8'hD8;
	localparam logic [7:0] M_MAP16   = 8'hD9;
	localparam logic [7:0] M_MAP32   = 8'hDA;

	// marker high nibbles
	localparam logic [3:0] N_TINY_STR  = 4'h8;
	localparam logic [3:0] N_TINY_LIST = 4'h9;
	localparam logic [3:0] N_TINY_MAP  = 4'hA;
	localparam logic [3:0] N_TINY_SIG  = 4'hB;
	localparam logic [3:0] N_NEG_INT   = 4'hF;

	typedef enum logic [3:0] {
		PH_MARKER  = 4'b0001,
		PH_HEADER  = 4'b0010,
		PH_SIG     = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  pending_kind;
		logic [3:0]  hdr_left;
		logic [3:0]  hdr_width;
		logic [63:0] acc;
		logic [30:0] pay_left;
		logic        halted;
	} state_t;

	localparam state_t ST_CLEAR = '{
		phase:        PH_MARKER,
		pending_kind: 4'd0,
		hdr_left:     4'd0,
		hdr_width:    4'd0,
		acc:          64'd0,
		pay_left:     31'd0,
		halted:       1'b0
	};

	typedef struct packed {
		logic [3:0]         kind;
		logic signed [63:0] value;
		logic [7:0]         code;
		logic [1:0]         err;
		logic               last;
	} token_t;

	typedef struct packed {
		logic [63:0] low;
		logic [63:0] high;
	} codes_t;

endpackage

// File: rtl/core/pst_in_if.sv
// input byte channel of the stream tokenizer
`timescale 1ns / 1ps
interface pst_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink (input valid, input data_byte, input restart, output ready);
endinterface

// File: rtl/core/pst_out_if.sv
// token output channel of the stream tokenizer
`timescale 1ns / 1ps
interface pst_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         token_kind;
	logic signed [63:0] token_value;
	logic [7:0]         struct_code;
	logic [1:0]         error_code;
	logic               last_payload;

	modport source (
		output valid, output token_kind, output token_value, output struct_code,
		output error_code, output last_payload, input ready
	);
	modport sink (
		input valid, input token_kind, input token_value, input struct_code,
		input error_code, input last_payload, output ready
	);
endinterface

// File: rtl/core/pst_cfg_if.sv
// configuration write channel of the stream tokenizer
`timescale 1ns / 1ps
interface pst_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pst_pkg::CfgAddrW-1:0]   addr;
	logic [63:0]                    wdata;

	modport source (output valid, output addr, output wdata, input ready);
	modport sink (input valid, input addr, input wdata, output ready);
endinterface

// File: rtl/core/pst_cfg_regs.sv
// accepted signature registers
`timescale 1ns / 1ps
module pst_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	pst_cfg_if.sink         cfg,
	output pst_pkg::codes_t codes
);

	logic [63:0] codes_low_q;
	logic [63:0] codes_high_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_low_q  <= '1;
			codes_high_q <= '1;
		end else if (cfg.valid) begin
			case (cfg.addr)
				pst_pkg::CFG_CODES_LOW:  codes_low_q  <= cfg.wdata;
				pst_pkg::CFG_CODES_HIGH: codes_high_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	assign codes.low  = codes_low_q;
	assign codes.high = codes_high_q;

endmodule

// File: rtl/core/pst_step.sv
// next-state and token logic for one stream byte
`timescale 1ns / 1ps
module pst_step (
	input  pst_pkg::state_t cur,
	input  logic [7:0]      data_byte,
	input  logic            restart,
	input  pst_pkg::codes_t codes,
	output pst_pkg::state_t nxt,
	output logic            emit,
	output pst_pkg::token_t tok
);

	pst_pkg::state_t st;
	logic [63:0]     acc_sh;
	logic [3:0]      hdr_dec;
	logic [30:0]     pay_dec;
	logic            sig_ok;
	logic            hdr_start;
	logic [3:0]      hdr_kind;
	logic [3:0]      hdr_n;
	logic            fail_en;
	logic [1:0]      fail_err;
	logic            size_en;
	logic [3:0]      size_kind;
	logic [31:0]     size_val;
	logic [63:0]     int_val;

	always_comb begin
		st        = restart ? pst_pkg::ST_CLEAR : cur;
		nxt       = st;
		emit      = 1'b0;
		tok       = '0;
		hdr_start = 1'b0;
		hdr_kind  = pst_pkg::K_NULL;
		hdr_n     = 4'd0;
		fail_en   = 1'b0;
		fail_err  = pst_pkg::E_NONE;
		size_en   = 1'b0;
		size_kind = pst_pkg::K_NULL;
		size_val  = 32'd0;
		acc_sh    = {st.acc[55:0], data_byte};
		hdr_dec   = (st.hdr_left != 4'd0) ? st.hdr_left - 4'd1 : 4'd0;
		pay_dec   = (st.pay_left != 31'd0) ? st.pay_left - 31'd1 : 31'd0;
		int_val   = acc_sh;

		if (data_byte[7]) begin
			sig_ok = 1'b0;
		end else if (data_byte[6]) begin
			sig_ok = codes.high[data_byte[5:0]];
		end else begin
			sig_ok = codes.low[data_byte[5:0]];
		end

		case (st.hdr_width)
			4'd1:    int_val = {{56{acc_sh[7]}}, acc_sh[7:0]};
			4'd2:    int_val = {{48{acc_sh[15]}}, acc_sh[15:0]};
			4'd4:    int_val = {{32{acc_sh[31]}}, acc_sh[31:0]};
			default: int_val = acc_sh;
		endcase

		if (restart || !cur.halted) begin
			nxt.phase = pst_pkg::PH_MARKER;
			case (st.phase)
				pst_pkg::PH_HEADER: begin
					nxt.acc      = acc_sh;
					nxt.hdr_left = hdr_dec;
					if (hdr_dec != 4'd0) begin
						nxt.phase = pst_pkg::PH_HEADER;
					end else if (st.pending_kind == pst_pkg::K_INT) begin
						emit       = 1'b1;
						tok.kind   = pst_pkg::K_INT;
						tok.value  = int_val;
					end else if (st.pending_kind == pst_pkg::K_FLOAT) begin
						emit       = 1'b1;
						tok.kind   = pst_pkg::K_FLOAT;
						tok.value  = acc_sh;
					end else if (acc_sh[31]) begin
						fail_en  = 1'b1;
						fail_err = pst_pkg::E_NEG_SIZE;
					end else begin
						size_en   = 1'b1;
						size_kind = st.pending_kind;
						size_val  = {1'b0, acc_sh[30:0]};
					end
				end
				pst_pkg::PH_SIG: begin
					if (!sig_ok) begin
						fail_en  = 1'b1;
						fail_err = pst_pkg::E_SIG;
					end else begin
						emit      = 1'b1;
						tok.kind  = pst_pkg::K_STRUCT;
						tok.value = {60'd0, st.acc[3:0]};
						tok.code  = data_byte;
					end
				end
				pst_pkg::PH_PAYLOAD: begin
					emit         = 1'b1;
					tok.kind     = pst_pkg::K_PAY;
					tok.value    = {56'd0, data_byte};
					nxt.pay_left = pay_dec;
					if (pay_dec == 31'd0) begin
						tok.last = 1'b1;
					end else begin
						nxt.phase = pst_pkg::PH_PAYLOAD;
					end
				end
				default: begin
					if (!data_byte[7]) begin
						emit      = 1'b1;
						tok.kind  = pst_pkg::K_INT;
						tok.value = {56'd0, data_byte};
					end else if (data_byte[7:4] == pst_pkg::N_NEG_INT) begin
						emit      = 1'b1;
						tok.kind  = pst_pkg::K_INT;
						tok.value = {{56{1'b1}}, data_byte};
					end else if (data_byte[7:4] == pst_pkg::N_TINY_STR) begin
						size_en   = 1'b1;
						size_kind = pst_pkg::K_STR;
						size_val  = {28'd0, data_byte[3:0]};
					end else if (data_byte[7:4] == pst_pkg::N_TINY_LIST) begin
						size_en   = 1'b1;
						size_kind = pst_pkg::K_LIST;
						size_val  = {28'd0, data_byte[3:0]};
					end else if (data_byte[7:4] == pst_pkg::N_TINY_MAP) begin
						size_en   = 1'b1;
						size_kind = pst_pkg::K_MAP;
						size_val  = {28'd0, data_byte[3:0]};
					end else if (data_byte[7:4] == pst_pkg::N_TINY_SIG) begin
						nxt.phase        = pst_pkg::PH_SIG;
						nxt.pending_kind = pst_pkg::K_STRUCT;
						nxt.acc          = {60'd0, data_byte[3:0]};
					end else begin
						case (data_byte)
							pst_pkg::M_NULL: begin
								emit     = 1'b1;
								tok.kind = pst_pkg::K_NULL;
							end
							pst_pkg::M_FALSE: begin
								emit     = 1'b1;
								tok.kind = pst_pkg::K_BOOL;
							end
							pst_pkg::M_TRUE: begin
								emit      = 1'b1;
								tok.kind  = pst_pkg::K_BOOL;
								tok.value = 64'sd1;
							end
							pst_pkg::M_FLOAT: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_FLOAT; hdr_n = 4'd8;
							end
							pst_pkg::M_INT8: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_INT; hdr_n = 4'd1;
							end
							pst_pkg::M_INT16: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_INT; hdr_n = 4'd2;
							end
							pst_pkg::M_INT32: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_INT; hdr_n = 4'd4;
							end
							pst_pkg::M_INT64: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_INT; hdr_n = 4'd8;
							end
							pst_pkg::M_BYTES8: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_BYTES; hdr_n = 4'd1;
							end
							pst_pkg::M_BYTES16: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_BYTES; hdr_n = 4'd2;
							end
							pst_pkg::M_BYTES32: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_BYTES; hdr_n = 4'd4;
							end
							pst_pkg::M_STR8: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_STR; hdr_n = 4'd1;
							end
							pst_pkg::M_STR16: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_STR; hdr_n = 4'd2;
							end
							pst_pkg::M_STR32: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_STR; hdr_n = 4'd4;
							end
							pst_pkg::M_LIST8: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_LIST; hdr_n = 4'd1;
							end
							pst_pkg::M_LIST16: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_LIST; hdr_n = 4'd2;
							end
							pst_pkg::M_LIST32: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_LIST; hdr_n = 4'd4;
							end
							pst_pkg::M_MAP8: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_MAP; hdr_n = 4'd1;
							end
							pst_pkg::M_MAP16: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_MAP; hdr_n = 4'd2;
							end
							pst_pkg::M_MAP32: begin
								hdr_start = 1'b1; hdr_kind = pst_pkg::K_MAP; hdr_n = 4'd4;
							end
							default: begin
								fail_en  = 1'b1;
								fail_err = pst_pkg::E_MARKER;
							end
						endcase
					end
				end
			endcase

			// start gathering header bytes
			if (hdr_start) begin
				nxt.phase        = pst_pkg::PH_HEADER;
				nxt.pending_kind = hdr_kind;
				nxt.hdr_left     = hdr_n;
				nxt.hdr_width    = hdr_n;
				nxt.acc          = 64'd0;
			end

			// size or count header, string and bytes with a nonzero size go on to payload
			if (size_en) begin
				emit      = 1'b1;
				tok.kind  = size_kind;
				tok.value = {32'd0, size_val};
				if ((size_kind == pst_pkg::K_STR || size_kind == pst_pkg::K_BYTES)
						&& size_val != 32'd0) begin
					nxt.phase    = pst_pkg::PH_PAYLOAD;
					nxt.pay_left = size_val[30:0];
				end
			end

			// error token, then halt until restart
			if (fail_en) begin
				emit         = 1'b1;
				tok          = '0;
				tok.kind     = pst_pkg::K_ERR;
				tok.err      = fail_err;
				nxt.halted   = 1'b1;
				nxt.phase    = pst_pkg::PH_MARKER;
				nxt.hdr_left = 4'd0;
				nxt.pay_left = 31'd0;
			end
		end
	end

endmodule

// File: rtl/core/packstream_stream_tokenizer_core.sv
// top level of the packstream stream tokenizer
`timescale 1ns / 1ps
// Takes one serialized byte per request on in_ch and gives at most one flat
// token per byte on out_ch (null, bool, int, float, string/bytes/list/map
// and structure headers, string and bytes payload bytes with the last one
// flagged, and error tokens). A byte is registered, decoded against the
// tokenizer state and its token lands in the result register; one byte
// every cycle is sustained while out_ch does not stall. While a token
// waits on out_ch, in_ch is ready only if the input register is empty.
// After an error token nothing comes out until a byte arrives with restart
// set. The cfg channel is always ready and writes the accepted signature
// masks (address 0 codes 0..63, address 1 codes 64..127; codes 128..255
// are always rejected); write it only while no request is in flight.
module packstream_stream_tokenizer_core (
	input logic        clk,
	input logic        arst_n,
	pst_in_if.sink     in_ch,
	pst_out_if.source  out_ch,
	pst_cfg_if.sink    cfg
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            restart_s1;
	logic            valid_s2;
	pst_pkg::token_t tok_s2;
	pst_pkg::state_t st_q;
	pst_pkg::state_t st_nxt;
	pst_pkg::codes_t codes;
	pst_pkg::token_t step_tok;
	logic            step_emit;
	logic            out_free;
	logic            adv;
	logic            out_load;

	pst_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.codes  (codes)
	);

	pst_step u_step (
		.cur       (st_q),
		.data_byte (byte_s1),
		.restart   (restart_s1),
		.codes     (codes),
		.nxt       (st_nxt),
		.emit      (step_emit),
		.tok       (step_tok)
	);

	assign out_free    = !valid_s2 || out_ch.ready;
	assign adv         = valid_s1 && out_free;
	assign out_load    = adv && step_emit;
	assign in_ch.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= pst_pkg::ST_CLEAR;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (out_free) begin
				valid_s2 <= out_load;
			end
			if (adv) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1    <= in_ch.data_byte;
			restart_s1 <= in_ch.restart;
		end
		if (out_load) begin
			tok_s2 <= step_tok;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.token_kind   = tok_s2.kind;
	assign out_ch.token_value  = tok_s2.value;
	assign out_ch.struct_code  = tok_s2.code;
	assign out_ch.error_code   = tok_s2.err;
	assign out_ch.last_payload = tok_s2.last;

	// an error token always leaves the block halted
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && step_tok.kind == pst_pkg::K_ERR) |=> st_q.halted)
		else $error("error token without halt");

	// the last payload byte returns to marker decoding
	a_last_to_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && step_tok.last) |=> (st_q.phase == pst_pkg::PH_MARKER))
		else $error("last payload byte did not end the payload");

	// halted and no restart means no token
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && st_q.halted && !restart_s1) |-> !step_emit)
		else $error("token produced while halted");

	// a signature only appears on structure headers
	a_code_on_struct: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && tok_s2.code != 8'd0) |-> (tok_s2.kind == pst_pkg::K_STRUCT))
		else $error("struct code on a non-structure token");

endmodule
